// ===== src/qlrs_pkg.sv =====
package qlrs_pkg;

   localparam int VALUE_W    = 32;
   localparam int DUR_W      = 24;
   localparam int ELAPSED_W  = 16;
   localparam int TIMER_W    = 32;
   localparam int COUNT_OUT_W = 5;
   localparam int DIV_STEPS  = 32;
   localparam int DIV_CNT_W  = 5;

   typedef enum logic [1:0] {
      OP_TICK       = 2'd0,
      OP_PUSH_BACK  = 2'd1,
      OP_PUSH_FRONT = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_RUN   = 2'd1,
      PH_END   = 2'd2
   } phase_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] target;
      logic [DUR_W-1:0]          duration;
   } cmd_type;

endpackage

// ===== src/queued_linear_ramp_sequencer.sv =====
// Ramp sequencer with a double-ended command queue.
//
// An item is taken on a rising edge with start high and busy low. req_op picks
// the operation: tick (req_elapsed time units passed), push back, push front
// (the current ramp restarts) or clear. Pushes carry req_command_target and
// req_command_duration. Every item gives exactly one result beat, shown on the
// rsp_ ports for one cycle with rsp_valid high; the receiver cannot stall.
//
// Push, clear and a tick on an empty queue answer the cycle after they are
// taken, and the next item may be taken in that same cycle. A tick first reads
// the head command from the queue RAM while waiting in ST_FETCH, so start and
// end ticks answer from ST_EVAL. A running tick with a nonzero duration
// multiplies, then feeds a restoring divider that retires one quotient bit
// per cycle; its result comes from ST_FIN after ST_EVAL, ST_MUL, ST_SUM,
// ST_ABS and ST_DIV, and the next item can be taken in that same cycle.
//
// Synchronous reset empties the queue, sets the start phase and zeros the
// timer, the ramp start and the shown value. The queue RAM is not cleared;
// only entries written by a push are ever used.
module queued_linear_ramp_sequencer #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [1:0]                                 req_op,
   input  logic signed [qlrs_pkg::VALUE_W-1:0]        req_command_target,
   input  logic [qlrs_pkg::DUR_W-1:0]                 req_command_duration,
   input  logic [qlrs_pkg::ELAPSED_W-1:0]             req_elapsed,
   output logic                                       rsp_valid,
   output logic signed [qlrs_pkg::VALUE_W-1:0]        rsp_shown_value,
   output logic                                       rsp_shown_updated,
   output logic [qlrs_pkg::COUNT_OUT_W-1:0]           rsp_commands_waiting,
   output logic [1:0]                                 rsp_ramp_phase,
   output logic                                       rsp_push_dropped
);

   localparam int HW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = CW + 1;
   localparam int VW    = qlrs_pkg::VALUE_W;
   localparam int DW    = qlrs_pkg::DUR_W;
   localparam int TW    = qlrs_pkg::TIMER_W;
   localparam logic [SUM_W-1:0] DEPTH_S   = SUM_W'(QUEUE_DEPTH);
   localparam logic [CW-1:0]    DEPTH_C   = CW'(QUEUE_DEPTH);
   localparam logic [HW-1:0]    LAST_HEAD = HW'(QUEUE_DEPTH - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_FETCH, ST_EVAL, ST_MUL, ST_SUM, ST_ABS, ST_DIV, ST_FIN
   } state_type;

   state_type                    state_ff;
   logic [HW-1:0]                head_ff;
   logic [CW-1:0]                count_ff;
   qlrs_pkg::phase_type          phase_ff;
   logic [TW-1:0]                timer_ff;
   logic signed [VW-1:0]         ramp_start_ff;
   logic signed [VW-1:0]         shown_ff;
   logic [qlrs_pkg::ELAPSED_W-1:0] elapsed_ff;
   logic                         rsp_valid_ff;
   logic                         updated_ff;
   logic                         dropped_ff;

   // Datapath of the interpolation.
   logic                         done_ff;
   logic [DW-1:0]                m_ff;
   logic signed [VW:0]           delta_ff;
   logic signed [VW+DW:0]        prod_a_ff;
   logic signed [VW+DW+1:0]      prod_b_ff;
   logic signed [VW+DW+2:0]      num_ff;
   logic                         neg_ff;
   logic [DW-1:0]                rem_ff;
   logic [VW-1:0]                qd_ff;
   logic [qlrs_pkg::DIV_CNT_W-1:0] div_cnt_ff;

   qlrs_pkg::cmd_type            cmd_mem_ff [QUEUE_DEPTH];
   qlrs_pkg::cmd_type            rd_ff;

   qlrs_pkg::op_type             op;
   logic                         accept;
   logic                         full;
   logic [HW-1:0]                head_pop;
   logic [HW-1:0]                head_prev;
   logic [SUM_W-1:0]             slot_sum;
   logic [SUM_W-1:0]             slot_wrap;
   logic [HW-1:0]                slot;
   logic                         mem_we;
   logic [HW-1:0]                mem_wa;
   qlrs_pkg::cmd_type            mem_wd;
   logic [TW-1:0]                timer_base;
   logic [TW:0]                  timer_sum;
   logic [TW-1:0]                timer_in;
   logic [DW-1:0]                m_in;
   logic [VW+DW+2:0]             num_abs;
   logic [DW:0]                  trial;
   logic [DW:0]                  dur_ext;
   logic                         trial_ge;
   logic [CW+qlrs_pkg::COUNT_OUT_W-1:0] count_wide;

   assign op        = qlrs_pkg::op_type'(req_op);
   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign full      = (count_ff == DEPTH_C);
   assign head_pop  = (head_ff == LAST_HEAD) ? '0 : head_ff + 1'b1;
   assign head_prev = (head_ff == '0) ? LAST_HEAD : head_ff - 1'b1;
   assign slot_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign slot_wrap = (slot_sum >= DEPTH_S) ? slot_sum - DEPTH_S : slot_sum;
   assign slot      = slot_wrap[HW-1:0];

   always_comb begin
      mem_we = 1'b0;
      mem_wa = slot;
      mem_wd.target   = req_command_target;
      mem_wd.duration = req_command_duration;
      if (accept && !full) begin
         if (op == qlrs_pkg::OP_PUSH_BACK) begin
            mem_we = 1'b1;
         end else if (op == qlrs_pkg::OP_PUSH_FRONT) begin
            mem_we = 1'b1;
            mem_wa = head_prev;
         end
      end
   end

   // The head entry is read every cycle; a tick waits in ST_FETCH,
   // so the read always sees writes made by earlier pushes.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cmd_mem_ff[mem_wa] <= mem_wd;
      end
      rd_ff <= cmd_mem_ff[head_ff];
   end

   // The start step zeros the timer before elapsed time is added.
   assign timer_base = (phase_ff == qlrs_pkg::PH_START) ? '0 : timer_ff;
   assign timer_sum  = {1'b0, timer_base} + (TW + 1)'(elapsed_ff);
   assign timer_in   = timer_sum[TW] ? '1 : timer_sum[TW-1:0];
   assign m_in       = (timer_ff < TW'(rd_ff.duration)) ? timer_ff[DW-1:0] : rd_ff.duration;
   assign num_abs    = num_ff[VW+DW+2] ? -num_ff : num_ff;
   assign dur_ext    = {1'b0, rd_ff.duration};
   assign trial      = {rem_ff, qd_ff[VW-1]};
   assign trial_ge   = (trial >= dur_ext);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         head_ff       <= '0;
         count_ff      <= '0;
         phase_ff      <= qlrs_pkg::PH_START;
         timer_ff      <= '0;
         ramp_start_ff <= '0;
         shown_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         updated_ff    <= 1'b0;
         dropped_ff    <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  updated_ff <= 1'b0;
                  dropped_ff <= 1'b0;
                  elapsed_ff <= req_elapsed;
                  case (op)
                     qlrs_pkg::OP_TICK: begin
                        if (count_ff != '0) begin
                           state_ff <= ST_FETCH;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                        end
                     end
                     qlrs_pkg::OP_PUSH_BACK: begin
                        rsp_valid_ff <= 1'b1;
                        if (full) begin
                           dropped_ff <= 1'b1;
                        end else begin
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     qlrs_pkg::OP_PUSH_FRONT: begin
                        rsp_valid_ff <= 1'b1;
                        phase_ff     <= qlrs_pkg::PH_START;
                        if (full) begin
                           dropped_ff <= 1'b1;
                        end else begin
                           head_ff  <= head_prev;
                           count_ff <= count_ff + 1'b1;
                        end
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        timer_ff     <= '0;
                        count_ff     <= '0;
                        phase_ff     <= qlrs_pkg::PH_START;
                     end
                  endcase
               end
            end
            ST_FETCH: begin
               state_ff <= ST_EVAL;
            end
            ST_EVAL: begin
               timer_ff <= timer_in;
               case (phase_ff)
                  qlrs_pkg::PH_START: begin
                     ramp_start_ff <= shown_ff;
                     phase_ff      <= qlrs_pkg::PH_RUN;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= ST_IDLE;
                  end
                  qlrs_pkg::PH_RUN: begin
                     if (rd_ff.duration == '0) begin
                        shown_ff     <= rd_ff.target;
                        phase_ff     <= qlrs_pkg::PH_END;
                        updated_ff   <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                        state_ff     <= ST_IDLE;
                     end else begin
                        // The old timer value sets both the fraction and the end test.
                        m_ff     <= m_in;
                        done_ff  <= (timer_ff >= TW'(rd_ff.duration));
                        delta_ff <= (VW + 1)'(rd_ff.target) - (VW + 1)'(ramp_start_ff);
                        state_ff <= ST_MUL;
                     end
                  end
                  qlrs_pkg::PH_END: begin
                     head_ff      <= head_pop;
                     count_ff     <= count_ff - 1'b1;
                     phase_ff     <= qlrs_pkg::PH_START;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
                  default: begin
                     phase_ff     <= qlrs_pkg::PH_START;
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= ST_IDLE;
                  end
               endcase
            end
            ST_MUL: begin
               prod_a_ff <= ramp_start_ff * $signed({1'b0, rd_ff.duration});
               prod_b_ff <= delta_ff * $signed({1'b0, m_ff});
               state_ff  <= ST_SUM;
            end
            ST_SUM: begin
               num_ff   <= (VW + DW + 3)'(prod_a_ff) + (VW + DW + 3)'(prod_b_ff);
               state_ff <= ST_ABS;
            end
            ST_ABS: begin
               // The quotient magnitude stays below 2^32, so the bits above
               // bit 31 already form a remainder smaller than the duration.
               neg_ff     <= num_ff[VW+DW+2];
               rem_ff     <= num_abs[VW+DW-1:VW];
               qd_ff      <= num_abs[VW-1:0];
               div_cnt_ff <= '0;
               state_ff   <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff     <= trial_ge ? DW'(trial - dur_ext) : trial[DW-1:0];
               qd_ff      <= {qd_ff[VW-2:0], trial_ge};
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == qlrs_pkg::DIV_CNT_W'(qlrs_pkg::DIV_STEPS - 1)) begin
                  state_ff <= ST_FIN;
               end
            end
            ST_FIN: begin
               shown_ff     <= neg_ff ? -$signed(qd_ff) : $signed(qd_ff);
               updated_ff   <= 1'b1;
               phase_ff     <= done_ff ? qlrs_pkg::PH_END : qlrs_pkg::PH_RUN;
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // The result beat shows the state as the item left it.
   assign count_wide           = {{qlrs_pkg::COUNT_OUT_W{1'b0}}, count_ff};
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_shown_value      = shown_ff;
   assign rsp_shown_updated    = updated_ff;
   assign rsp_commands_waiting = count_wide[qlrs_pkg::COUNT_OUT_W-1:0];
   assign rsp_ramp_phase       = phase_ff;
   assign rsp_push_dropped     = dropped_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("queue count above depth");

   a_head_bounded: assert property (@(posedge clock) disable iff (reset)
      head_ff <= LAST_HEAD)
      else $error("queue head out of range");

   a_quick_items: assert property (@(posedge clock) disable iff (reset)
      (accept && op != qlrs_pkg::OP_TICK) |=> rsp_valid_ff)
      else $error("push or clear did not answer in the next cycle");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && dropped_ff) |-> full)
      else $error("push dropped while the queue had room");

   a_update_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && updated_ff) |-> (phase_ff != qlrs_pkg::PH_START))
      else $error("shown value written in the start phase");

   a_no_beat_while_dividing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> !rsp_valid_ff)
      else $error("result beat during division");

endmodule

// ===== test/queued_linear_ramp_sequencer_test.sv =====
module queued_linear_ramp_sequencer_test;

   localparam int QD = 16;
   localparam int RANDOM_ITEMS = 1250;
   localparam int ITEM_CAP = 1700;
   localparam int DUE_DEPTH = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int VW = qlrs_pkg::VALUE_W;
   localparam int DW = qlrs_pkg::DUR_W;
   localparam int EW = qlrs_pkg::ELAPSED_W;
   localparam int TW = qlrs_pkg::TIMER_W;
   localparam int OW = qlrs_pkg::COUNT_OUT_W;

   typedef struct {
      qlrs_pkg::op_type     op;
      logic signed [VW-1:0] target;
      logic [DW-1:0]        duration;
      logic [EW-1:0]        elapsed;
   } ramp_item_type;

   typedef struct {
      logic signed [VW-1:0] value;
      logic                 updated;
      logic [OW-1:0]        waiting;
      qlrs_pkg::phase_type  phase;
      logic                 dropped;
   } ramp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = qlrs_pkg::OP_TICK;
   logic signed [VW-1:0] req_command_target = '0;
   logic [DW-1:0] req_command_duration = '0;
   logic [EW-1:0] req_elapsed = '0;
   logic rsp_valid;
   logic signed [VW-1:0] rsp_shown_value;
   logic rsp_shown_updated;
   logic [OW-1:0] rsp_commands_waiting;
   logic [1:0] rsp_ramp_phase;
   logic rsp_push_dropped;

   queued_linear_ramp_sequencer #(.QUEUE_DEPTH(QD)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_command_target(req_command_target),
      .req_command_duration(req_command_duration),
      .req_elapsed(req_elapsed),
      .rsp_valid(rsp_valid),
      .rsp_shown_value(rsp_shown_value),
      .rsp_shown_updated(rsp_shown_updated),
      .rsp_commands_waiting(rsp_commands_waiting),
      .rsp_ramp_phase(rsp_ramp_phase),
      .rsp_push_dropped(rsp_push_dropped)
   );

   always #5 clock = ~clock;

   // Items waiting to be driven, filled once and then read in order.
   ramp_item_type   pending_items[ITEM_CAP];
   int              item_fill = 0;
   int              item_next = 0;

   // Predicted beats in flight, oldest at due_rd.
   ramp_result_type due_ring[DUE_DEPTH];
   int              due_wr = 0;
   int              due_rd = 0;

   // Predicted state of the sequencer.
   qlrs_pkg::cmd_type    model_queue[QD];
   int                   model_head = 0;
   int                   model_count = 0;
   qlrs_pkg::phase_type  model_phase = qlrs_pkg::PH_START;
   logic [TW-1:0]        model_timer = '0;
   logic signed [VW-1:0] model_start = '0;
   logic signed [VW-1:0] model_shown = '0;

   int n_mismatch = 0;
   int n_checked = 0;
   int n_updates = 0;
   int n_dropped = 0;
   int op_count[4] = '{0, 0, 0, 0};
   int cycle_count = 0;

   function automatic ramp_item_type make_item(qlrs_pkg::op_type op,
                                               logic signed [VW-1:0] tgt,
                                               logic [DW-1:0] dur, logic [EW-1:0] el);
      ramp_item_type it;
      it.op = op;
      it.target = tgt;
      it.duration = dur;
      it.elapsed = el;
      return it;
   endfunction

   function automatic void add_item(ramp_item_type it);
      if (item_fill < ITEM_CAP) begin
         pending_items[item_fill] = it;
         item_fill++;
      end
   endfunction

   function automatic logic [DW-1:0] rnd_dur();
      return DW'($urandom());
   endfunction

   function automatic logic [EW-1:0] rnd_el();
      return EW'($urandom());
   endfunction

   function automatic logic signed [VW-1:0] pick_target();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return 32'sh7FFFFFFF;
      if (sel == 1) return 32'sh80000000;
      if (sel == 2) return '0;
      return $urandom();
   endfunction

   function automatic logic [DW-1:0] pick_duration();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 15) return '0;
      if (sel < 65) return DW'($urandom_range(1, 16));
      if (sel < 85) return DW'($urandom_range(17, 4095));
      if (sel < 90) return '1;
      return rnd_dur();
   endfunction

   // Advances the predicted state by one item and returns the beat it should produce.
   task automatic advance_ramp(input ramp_item_type it, output ramp_result_type r);
      qlrs_pkg::cmd_type head_cmd;
      longint  reach, span, num, dur_l, sum;
      r.updated = 1'b0;
      r.dropped = 1'b0;
      case (it.op)
         qlrs_pkg::OP_TICK: begin
            if (model_count != 0) begin
               head_cmd = model_queue[model_head];
               case (model_phase)
                  qlrs_pkg::PH_START: begin
                     model_start = model_shown;
                     model_timer = '0;
                     model_phase = qlrs_pkg::PH_RUN;
                  end
                  qlrs_pkg::PH_RUN: begin
                     if (head_cmd.duration == '0) begin
                        model_shown = head_cmd.target;
                        model_phase = qlrs_pkg::PH_END;
                     end else begin
                        dur_l = longint'({8'd0, head_cmd.duration});
                        reach = (model_timer < TW'(head_cmd.duration))
                              ? longint'({32'd0, model_timer}) : dur_l;
                        span = longint'($signed(head_cmd.target)) - longint'(model_start);
                        num = longint'(model_start) * dur_l + span * reach;
                        model_shown = 32'(num / dur_l);
                        if (model_timer >= TW'(head_cmd.duration))
                           model_phase = qlrs_pkg::PH_END;
                     end
                     r.updated = 1'b1;
                  end
                  default: begin
                     model_head = (model_head + 1) % QD;
                     model_count--;
                     model_phase = qlrs_pkg::PH_START;
                  end
               endcase
               sum = longint'({32'd0, model_timer}) + longint'({48'd0, it.elapsed});
               model_timer = (sum > 64'hFFFFFFFF) ? '1 : sum[31:0];
            end
         end
         qlrs_pkg::OP_PUSH_BACK: begin
            if (model_count >= QD) begin
               r.dropped = 1'b1;
            end else begin
               model_queue[(model_head + model_count) % QD] = '{it.target, it.duration};
               model_count++;
            end
         end
         qlrs_pkg::OP_PUSH_FRONT: begin
            model_phase = qlrs_pkg::PH_START;
            if (model_count >= QD) begin
               r.dropped = 1'b1;
            end else begin
               model_head = (model_head + QD - 1) % QD;
               model_queue[model_head] = '{it.target, it.duration};
               model_count++;
            end
         end
         default: begin
            model_timer = '0;
            model_count = 0;
            model_phase = qlrs_pkg::PH_START;
         end
      endcase
      r.value = model_shown;
      r.waiting = OW'(model_count);
      r.phase = model_phase;
   endtask

   // Driver: bursts of items separated by random gaps.
   ramp_item_type cur_item;
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      ramp_result_type due;
      if (!reset) begin
         if (start && !busy) begin
            advance_ramp(cur_item, due);
            due_ring[due_wr % DUE_DEPTH] = due;
            due_wr++;
            op_count[cur_item.op]++;
            if (due.updated) n_updates++;
            if (due.dropped) n_dropped++;
         end
         if (!start || !busy) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (item_next < item_fill) begin
               cur_item = pending_items[item_next];
               item_next++;
               req_op <= cur_item.op;
               req_command_target <= cur_item.target;
               req_command_duration <= cur_item.duration;
               req_elapsed <= cur_item.elapsed;
               start <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  if ($urandom_range(0, 7) == 0) begin
                     burst_left = 200;
                     gap_left = 0;
                  end else begin
                     burst_left = $urandom_range(1, 30);
                     gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45)
                                                            : $urandom_range(0, 4);
                  end
               end
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every result beat is checked against the oldest prediction.
   always @(posedge clock) begin
      ramp_result_type want;
      if (!reset && rsp_valid) begin
         if (due_wr == due_rd) begin
            if (n_mismatch < 10)
               $display("mismatch: unexpected beat value=%0d upd=%0b waiting=%0d ph=%0d",
                        rsp_shown_value, rsp_shown_updated, rsp_commands_waiting,
                        rsp_ramp_phase);
            n_mismatch++;
         end else begin
            want = due_ring[due_rd % DUE_DEPTH];
            due_rd++;
            n_checked++;
            if (rsp_shown_value !== want.value || rsp_shown_updated !== want.updated ||
                rsp_commands_waiting !== want.waiting || rsp_ramp_phase !== want.phase ||
                rsp_push_dropped !== want.dropped) begin
               if (n_mismatch < 10) begin
                  $display("mismatch at beat %0d:", n_checked);
                  $display("  expected value=%0d upd=%0b waiting=%0d ph=%0d drop=%0b",
                           want.value, want.updated, want.waiting, want.phase, want.dropped);
                  $display("  actual   value=%0d upd=%0b waiting=%0d ph=%0d drop=%0b",
                           rsp_shown_value, rsp_shown_updated, rsp_commands_waiting,
                           rsp_ramp_phase, rsp_push_dropped);
               end
               n_mismatch++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      int            n_cmds, n_ticks, sel, directed;
      bit            truncated;
      logic [DW-1:0] d, max_d, step;
      logic [EW-1:0] el;
      logic [DW-1:0] durs[4];

      // Directed part: empty-queue tick, zero duration jump, extreme targets and
      // durations, a push front restarting a ramp, and a clear.
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'hFFFF));
      add_item(make_item(qlrs_pkg::OP_PUSH_BACK, 32'sh7FFFFFFF, '0, '0));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, '0));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd7));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd1));
      add_item(make_item(qlrs_pkg::OP_PUSH_BACK, 32'sh80000000, 24'hFFFFFF, '0));
      add_item(make_item(qlrs_pkg::OP_PUSH_BACK, '0, 24'd1, '0));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'hFFFF));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'hFFFF));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'hFFFF));
      add_item(make_item(qlrs_pkg::OP_PUSH_FRONT, -32'sd1000, 24'd5, '0));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, '0));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd3));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd3));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd3));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd3));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd3));
      add_item(make_item(qlrs_pkg::OP_CLEAR, 32'sh7FFFFFFF, 24'hFFFFFF, 16'hFFFF));
      add_item(make_item(qlrs_pkg::OP_TICK, '0, '0, 16'd9));
      directed = item_fill;

      while (item_fill < directed + RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            // A few ramps pushed and then played through with a steady tick size.
            n_cmds = $urandom_range(1, 4);
            max_d = '0;
            for (int i = 0; i < n_cmds; i++) begin
               d = pick_duration();
               durs[i] = d;
               if (d > max_d) max_d = d;
               add_item(make_item(
                  ($urandom_range(0, 3) == 0) ? qlrs_pkg::OP_PUSH_FRONT
                                              : qlrs_pkg::OP_PUSH_BACK,
                  pick_target(), d, rnd_el()));
            end
            if (max_d <= 64) begin
               el = EW'($urandom_range(1, 8));
            end else begin
               step = max_d / DW'($urandom_range(2, 10));
               if (step > 65535) el = '1;
               else el = EW'(step) | 16'd1;
            end
            n_ticks = 0;
            for (int i = 0; i < n_cmds; i++) n_ticks += int'(durs[i] / DW'(el)) + 3;
            truncated = (n_ticks > 60);
            if (truncated) n_ticks = 60;
            n_ticks += $urandom_range(0, 2);
            for (int i = 0; i < n_ticks; i++) begin
               if ($urandom_range(0, 39) == 0)
                  add_item(make_item(qlrs_pkg::OP_PUSH_FRONT, pick_target(),
                                     pick_duration(), rnd_el()));
               if ($urandom_range(0, 11) == 0)
                  add_item(make_item(qlrs_pkg::OP_TICK, $urandom(), rnd_dur(),
                                     EW'($urandom_range(0, 65535))));
               else
                  add_item(make_item(qlrs_pkg::OP_TICK, $urandom(), rnd_dur(), el));
            end
            if (truncated)
               add_item(make_item(qlrs_pkg::OP_CLEAR, $urandom(), rnd_dur(), rnd_el()));
         end else if (sel < 80) begin
            // Overfill the queue so that pushes at both ends get dropped.
            n_cmds = $urandom_range(14, 19);
            for (int i = 0; i < n_cmds; i++)
               add_item(make_item(
                  ($urandom_range(0, 1) == 0) ? qlrs_pkg::OP_PUSH_FRONT
                                              : qlrs_pkg::OP_PUSH_BACK,
                  $urandom(), rnd_dur(), rnd_el()));
            n_ticks = $urandom_range(0, 6);
            for (int i = 0; i < n_ticks; i++)
               add_item(make_item(qlrs_pkg::OP_TICK, $urandom(), rnd_dur(), rnd_el()));
            if ($urandom_range(0, 1) == 0)
               add_item(make_item(qlrs_pkg::OP_CLEAR, $urandom(), rnd_dur(), rnd_el()));
         end else begin
            n_cmds = $urandom_range(1, 6);
            for (int i = 0; i < n_cmds; i++)
               add_item(make_item(qlrs_pkg::op_type'(2'($urandom_range(0, 3))),
                                  $urandom(), rnd_dur(), rnd_el()));
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (item_next < item_fill || start) @(posedge clock);
      while (due_wr != due_rd) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d beats checked: %0d ticks, %0d back pushes, %0d front pushes, %0d clears",
               n_checked, op_count[qlrs_pkg::OP_TICK], op_count[qlrs_pkg::OP_PUSH_BACK],
               op_count[qlrs_pkg::OP_PUSH_FRONT], op_count[qlrs_pkg::OP_CLEAR]);
      $display("%0d shown value updates, %0d dropped pushes, %0d mismatches",
               n_updates, n_dropped, n_mismatch);
      if (n_mismatch == 0 && due_wr == due_rd) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
